@@ rtl/sha256sh_pkg.sv @@
// Package for the streaming SHA-256 hasher: round constants, initial hash
// value and the types shared by the top level and the compression core.
// No dependencies.
`timescale 1ns / 1ps

package sha256sh_pkg;

    localparam int WordW  = 32;
    localparam int Rounds = 64;
    localparam int HashWords = 8;

    typedef logic [HashWords-1:0][WordW-1:0] hash_t;

    // Control from the sequencer in the top level to the compression core.
    typedef struct packed {
        logic       byte_en;   // shift one byte into the block buffer
        logic [7:0] byte_val;
        logic       start;     // compress the buffered block
        logic       init;      // return the chaining value to the initial hash
    } core_ctrl_t;

    localparam logic [WordW-1:0] RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam hash_t InitHash = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PadMarker = 8'h80;

endpackage

@@ rtl/sha256sh_core.sv @@
// SHA-256 compression core: 512-bit block buffer that doubles as the
// message schedule window, one round per cycle, chaining value update.
// Depends on sha256sh_pkg.
`timescale 1ns / 1ps

module sha256sh_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sha256sh_pkg::core_ctrl_t ctrl,
    output logic                     busy,
    output sha256sh_pkg::hash_t      hash
);
    import sha256sh_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} core_state_t;

    core_state_t state_reg;
    logic [5:0]  round_reg;
    logic [511:0] buf_reg;
    hash_t       hash_reg;
    hash_t       v_reg;
    hash_t       v_next;

    logic [WordW-1:0] w0, w1, w9, w14, w_new;
    logic [WordW-1:0] sig0, sig1, bs0, bs1, ch, maj, t1, t2;

    function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    // Oldest schedule word sits in the top bits.
    assign w0  = buf_reg[511:480];
    assign w1  = buf_reg[479:448];
    assign w9  = buf_reg[223:192];
    assign w14 = buf_reg[63:32];

    always_comb begin
        sig0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
        sig1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
        w_new = w0 + sig0 + w9 + sig1;

        bs1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1  = v_reg[7] + bs1 + ch + RoundK[round_reg] + w0;
        bs0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2  = bs0 + maj;

        v_next    = v_reg;
        v_next[7] = v_reg[6];
        v_next[6] = v_reg[5];
        v_next[5] = v_reg[4];
        v_next[4] = v_reg[3] + t1;
        v_next[3] = v_reg[2];
        v_next[2] = v_reg[1];
        v_next[1] = v_reg[0];
        v_next[0] = t1 + t2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            hash_reg  <= InitHash;
        end else begin
            unique case (state_reg)
                C_IDLE: begin
                    if (ctrl.byte_en) begin
                        buf_reg <= {buf_reg[503:0], ctrl.byte_val};
                    end
                    if (ctrl.init) begin
                        hash_reg <= InitHash;
                    end
                    if (ctrl.start) begin
                        v_reg     <= hash_reg;
                        round_reg <= '0;
                        state_reg <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    v_reg     <= v_next;
                    buf_reg   <= {buf_reg[479:0], w_new};
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'(Rounds - 1)) begin
                        state_reg <= C_ADD;
                    end
                end
                C_ADD: begin
                    for (int i = 0; i < HashWords; i++) begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != C_IDLE);
    assign hash = hash_reg;

endmodule

@@ rtl/sha256_stream_hasher.sv @@
// Streaming SHA-256 hasher top level: byte intake, padding sequencer and
// digest output. Depends on sha256sh_pkg and sha256sh_core.
//
//   channel | direction | tdata              | tuser            | tlast
//   s_      | in        | [7:0] message_byte | [0] byte_present | end_of_message
//   m_      | out       | [31:0] digest_word | [2:0] word_index | last_word
//
// Each full 64-byte block holds s_tready low for the 64 rounds of the shared
// round unit, the chaining update and the hand-back. End of message pushes
// the padding byte by byte, pausing while a full block is compressed, runs
// one or two compressions and presents eight digest beats.
// Reset (aresetn low, synchronous) restores the initial hash and clears counts.
// A stalled m_ side holds the current digest beat; no input is taken meanwhile.
`timescale 1ns / 1ps

module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] message_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);
    import sha256sh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MARK, ST_ZERO, ST_LEN, ST_BUSY, ST_OUT
    } state_t;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic [5:0]  count_reg, count_next;
    logic [60:0] len_reg, len_next;
    logic [2:0]  oidx_reg, oidx_next;

    core_ctrl_t  ctrl;
    logic        core_busy;
    hash_t       hash;
    logic [63:0] bit_len;
    logic        s_acc, m_acc;

    sha256sh_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .busy    (core_busy),
        .hash    (hash)
    );

    assign bit_len = {len_reg, 3'b000};
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_acc    = m_tvalid && m_tready;
    assign m_tdata  = hash[oidx_reg];
    assign m_tuser  = oidx_reg;
    assign m_tlast  = (oidx_reg == 3'd7);

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        count_next = count_reg;
        len_next   = len_reg;
        oidx_next  = oidx_reg;
        ctrl       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser) begin
                        ctrl.byte_en  = 1'b1;
                        ctrl.byte_val = s_tdata;
                        count_next    = count_reg + 6'd1;
                        len_next      = len_reg + 61'd1;
                    end
                    if (s_tuser && count_reg == 6'd63) begin
                        // block full: compress, then pad if the message closes
                        ctrl.start = 1'b1;
                        state_next = ST_BUSY;
                        ret_next   = s_tlast ? ST_MARK : ST_IDLE;
                    end else if (s_tlast) begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                ctrl.byte_en  = 1'b1;
                ctrl.byte_val = PadMarker;
                count_next    = count_reg + 6'd1;
                if (count_reg == 6'd63) begin
                    ctrl.start = 1'b1;
                    ret_next   = ST_ZERO;
                    state_next = ST_BUSY;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (count_reg == 6'd56) begin
                    state_next = ST_LEN;
                end else begin
                    ctrl.byte_en  = 1'b1;
                    ctrl.byte_val = 8'h00;
                    count_next    = count_reg + 6'd1;
                    if (count_reg == 6'd63) begin
                        ctrl.start = 1'b1;
                        ret_next   = ST_ZERO;
                        state_next = ST_BUSY;
                    end
                end
            end
            ST_LEN: begin
                // big-endian bit length, most significant byte first
                ctrl.byte_en  = 1'b1;
                ctrl.byte_val = bit_len[{~count_reg[2:0], 3'b000} +: 8];
                count_next    = count_reg + 6'd1;
                if (count_reg == 6'd63) begin
                    ctrl.start = 1'b1;
                    ret_next   = ST_OUT;
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (!core_busy) begin
                    state_next = ret_reg;
                end
            end
            ST_OUT: begin
                if (m_acc) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        ctrl.init  = 1'b1;
                        len_next   = '0;
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            count_reg <= '0;
            len_reg   <= '0;
            oidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            oidx_reg  <= oidx_next;
        end
    end

endmodule
